// File: sv/tgb_pkg.sv
// ============================================================================
// tgb_pkg
// Shared types and constants for the touch gesture to button mask block.
// ============================================================================
package tgb_pkg;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned TIME_W  = 48;
    localparam int unsigned DUR_W   = 24;
    localparam int unsigned MASK_W  = 8;
    localparam int unsigned CNT_W   = 2;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDAT_W  = 24;

    // button bits
    localparam logic [MASK_W-1:0] BTN_UP    = 8'h01;
    localparam logic [MASK_W-1:0] BTN_DOWN  = 8'h02;
    localparam logic [MASK_W-1:0] BTN_LEFT  = 8'h04;
    localparam logic [MASK_W-1:0] BTN_RIGHT = 8'h08;
    localparam logic [MASK_W-1:0] BTN_FIRE  = 8'h10;
    localparam logic [MASK_W-1:0] BTN_USE   = 8'h20;
    localparam logic [MASK_W-1:0] BTN_ESC   = 8'h40;
    localparam logic [MASK_W-1:0] BTN_ENTER = 8'h80;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // register indexes
    localparam logic [CIDX_W-1:0] REG_DIR_MARGIN     = 3'd0;
    localparam logic [CIDX_W-1:0] REG_DRAG_SLOP      = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TAP_MAX_US     = 3'd2;
    localparam logic [CIDX_W-1:0] REG_LONG_PRESS_US  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_PULSE_US       = 3'd4;
    localparam logic [CIDX_W-1:0] REG_SPLIT_X        = 3'd5;
    localparam logic [CIDX_W-1:0] REG_FLIP_Y_MAX     = 3'd6;

    // register reset values
    localparam logic [COORD_W-1:0] RST_DIR_MARGIN     = 10'd30;
    localparam logic [COORD_W-1:0] RST_DRAG_SLOP      = 10'd25;
    localparam logic [DUR_W-1:0]   RST_TAP_MAX_US     = 24'd400000;
    localparam logic [DUR_W-1:0]   RST_LONG_PRESS_US  = 24'd600000;
    localparam logic [DUR_W-1:0]   RST_PULSE_US       = 24'd120000;
    localparam logic [COORD_W-1:0] RST_SPLIT_X        = 10'd233;
    localparam logic [COORD_W-1:0] RST_FLIP_Y_MAX     = 10'd465;

    typedef struct packed {
        logic [COORD_W-1:0] dir_margin;
        logic [COORD_W-1:0] drag_slop;
        logic [DUR_W-1:0]   tap_max_us;
        logic [DUR_W-1:0]   long_press_us;
        logic [DUR_W-1:0]   pulse_us;
        logic [COORD_W-1:0] split_x;
        logic [COORD_W-1:0] flip_y_max;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]   finger_count;
        logic [COORD_W-1:0] raw_x;
        logic [COORD_W-1:0] raw_y;
        logic [TIME_W-1:0]  now_us;
    } t_poll;

    typedef struct packed {
        logic               was_touched;
        logic               is_dragging;
        logic               escape_sent;
        logic [COORD_W-1:0] origin_x;
        logic signed [COORD_W:0] origin_y;   // flipped y can go negative
        logic [TIME_W-1:0]  press_time;
        logic [TIME_W-1:0]  pulse_end_time;
        logic [MASK_W-1:0]  pulse_bits;
        logic [MASK_W-1:0]  previous_mask;
    } t_state;

endpackage

// File: sv/tgb_in_if.sv
// ============================================================================
// tgb_in_if
// Poll channel: valid/ready handshake with one touch-panel poll as payload.
// ============================================================================
interface tgb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  finger_count;
    logic [9:0]  raw_x;
    logic [9:0]  raw_y;
    logic [47:0] now_us;

    modport source (output valid, finger_count, raw_x, raw_y, now_us, input ready);
    modport sink   (input valid, finger_count, raw_x, raw_y, now_us, output ready);
endinterface

// File: sv/tgb_out_if.sv
// ============================================================================
// tgb_out_if
// Result channel: valid/ready handshake carrying button and change masks.
// ============================================================================
interface tgb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] button_mask;
    logic [7:0] changed_mask;

    modport source (output valid, button_mask, changed_mask, input ready);
    modport sink   (input valid, button_mask, changed_mask, output ready);
endinterface

// File: sv/tgb_cfg_if.sv
// ============================================================================
// tgb_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface tgb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/touch_gesture_to_buttons.sv
// ============================================================================
// touch_gesture_to_buttons
// Turns touch-panel polls into an 8-bit button mask and a change mask.
// ============================================================================
// Usage:
//   i_in   carries one poll per transfer (finger count, x, raw y, timestamp).
//   o_out  carries one result per poll: button mask and changed bits.
//   i_cfg  writes the seven tuning registers by index; always ready. Write
//          only while no poll is in flight.
// Path: a poll is registered on input, evaluated and registered on output.
// Throughput: one poll per cycle while o_out is ready; the gesture state
//   update is a single pass between the input register and the result register.
// Stall: while o_out is held, the input register still takes one more poll;
//   further polls wait on i_in.ready. Nothing is dropped.
// Reset: registers return to their default values, gesture state and the
//   previous mask are cleared, both channels come up empty.
// ============================================================================
module touch_gesture_to_buttons (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tgb_in_if.sink    i_in,
    tgb_out_if.source o_out,
    tgb_cfg_if.sink   i_cfg
);
    import tgb_pkg::*;

    t_cfg              cfg;
    t_poll             r_poll;
    logic              r_poll_vld;
    t_state            r_state;
    t_state            n_state;
    logic [MASK_W-1:0] n_mask;
    logic [MASK_W-1:0] n_changed;
    logic [MASK_W-1:0] r_mask;
    logic [MASK_W-1:0] r_changed;
    logic              r_out_vld;
    logic              adv;
    logic              in_xfer;

    assign i_cfg.ready = 1'b1;

    tgb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_idx   (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    tgb_gesture u_gesture (
        .i_cfg     (cfg),
        .i_state   (r_state),
        .i_poll    (r_poll),
        .o_state   (n_state),
        .o_mask    (n_mask),
        .o_changed (n_changed)
    );

    assign adv         = r_poll_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_poll_vld || adv;
    assign in_xfer     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_vld <= 1'b0;
        end else if (in_xfer) begin
            r_poll_vld <= 1'b1;
        end else if (adv) begin
            r_poll_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_poll.finger_count <= i_in.finger_count;
            r_poll.raw_x        <= i_in.raw_x;
            r_poll.raw_y        <= i_in.raw_y;
            r_poll.now_us       <= i_in.now_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_state   <= n_state;
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mask    <= n_mask;
            r_changed <= n_changed;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.button_mask  = r_mask;
    assign o_out.changed_mask = r_changed;
endmodule

// File: sv/tgb_cfg_regs.sv
// ============================================================================
// tgb_cfg_regs
// Configuration register file; unknown indexes are ignored.
// ============================================================================
module tgb_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr,
    input  logic [tgb_pkg::CIDX_W-1:0] i_idx,
    input  logic [tgb_pkg::CDAT_W-1:0] i_data,
    output tgb_pkg::t_cfg             o_cfg
);
    import tgb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_idx)
                REG_DIR_MARGIN:     n_cfg.dir_margin     = i_data[COORD_W-1:0];
                REG_DRAG_SLOP:      n_cfg.drag_slop      = i_data[COORD_W-1:0];
                REG_TAP_MAX_US:     n_cfg.tap_max_us     = i_data[DUR_W-1:0];
                REG_LONG_PRESS_US:  n_cfg.long_press_us  = i_data[DUR_W-1:0];
                REG_PULSE_US:       n_cfg.pulse_us       = i_data[DUR_W-1:0];
                REG_SPLIT_X:        n_cfg.split_x        = i_data[COORD_W-1:0];
                REG_FLIP_Y_MAX:     n_cfg.flip_y_max     = i_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dir_margin     <= RST_DIR_MARGIN;
            r_cfg.drag_slop      <= RST_DRAG_SLOP;
            r_cfg.tap_max_us     <= RST_TAP_MAX_US;
            r_cfg.long_press_us  <= RST_LONG_PRESS_US;
            r_cfg.pulse_us       <= RST_PULSE_US;
            r_cfg.split_x        <= RST_SPLIT_X;
            r_cfg.flip_y_max     <= RST_FLIP_Y_MAX;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// File: sv/tgb_gesture.sv
// ============================================================================
// tgb_gesture
// Gesture step: next tracking state and button mask for one poll.
// ============================================================================
module tgb_gesture (
    input  tgb_pkg::t_cfg              i_cfg,
    input  tgb_pkg::t_state            i_state,
    input  tgb_pkg::t_poll             i_poll,
    output tgb_pkg::t_state            o_state,
    output logic [tgb_pkg::MASK_W-1:0] o_mask,
    output logic [tgb_pkg::MASK_W-1:0] o_changed
);
    import tgb_pkg::*;

    logic                    touched;
    logic                    new_press;
    logic signed [COORD_W:0] y;
    logic [COORD_W-1:0]      org_x;
    logic signed [COORD_W:0] org_y;
    logic [TIME_W-1:0]       org_t;
    logic signed [COORD_W+1:0] dx, dy, adx, ady, thr, dz;
    logic [TIME_W:0]         held;
    logic                    held_gt_long;
    logic                    held_lt_tap;
    logic [TIME_W:0]         dl_sum;
    logic [TIME_W-1:0]       deadline;
    logic                    drag0, drag1, esc0;
    logic                    armed;
    logic                    show;
    logic [MASK_W-1:0]       mask;

    always_comb begin
        touched   = |i_poll.finger_count;
        new_press = touched && !i_state.was_touched;

        if (i_cfg.flip_y_max != '0) begin
            y = $signed({1'b0, i_cfg.flip_y_max}) - $signed({1'b0, i_poll.raw_y});
        end else begin
            y = $signed({1'b0, i_poll.raw_y});
        end

        org_x = new_press ? i_poll.raw_x  : i_state.origin_x;
        org_y = new_press ? y             : i_state.origin_y;
        org_t = new_press ? i_poll.now_us : i_state.press_time;
        drag0 = new_press ? 1'b0 : i_state.is_dragging;
        esc0  = new_press ? 1'b0 : i_state.escape_sent;

        dx  = $signed({2'b00, i_poll.raw_x}) - $signed({2'b00, org_x});
        dy  = $signed({y[COORD_W], y}) - $signed({org_y[COORD_W], org_y});
        adx = dx[COORD_W+1] ? -dx : dx;
        ady = dy[COORD_W+1] ? -dy : dy;
        thr = $signed({2'b00, i_cfg.drag_slop});
        dz  = $signed({2'b00, i_cfg.dir_margin});

        held         = {1'b0, i_poll.now_us} - {1'b0, org_t};
        held_gt_long = !held[TIME_W] &&
                       (held[TIME_W-1:0] > {{(TIME_W-DUR_W){1'b0}}, i_cfg.long_press_us});
        held_lt_tap  = held[TIME_W] ||
                       (held[TIME_W-1:0] < {{(TIME_W-DUR_W){1'b0}}, i_cfg.tap_max_us});

        dl_sum   = {1'b0, i_poll.now_us} + {{(TIME_W+1-DUR_W){1'b0}}, i_cfg.pulse_us};
        deadline = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];

        o_state             = i_state;
        o_state.origin_x    = org_x;
        o_state.origin_y    = org_y;
        o_state.press_time  = org_t;
        o_state.escape_sent = esc0;
        o_state.was_touched = touched;
        mask  = '0;
        armed = 1'b0;
        drag1 = drag0 || (adx > thr) || (ady > thr);

        if (touched) begin
            o_state.is_dragging = drag1;
            if (drag1) begin
                if (dy < -dz) mask = mask | BTN_UP;
                if (dy > dz)  mask = mask | BTN_DOWN;
                if (dx < -dz) mask = mask | BTN_LEFT;
                if (dx > dz)  mask = mask | BTN_RIGHT;
                if (i_poll.finger_count[1]) mask = mask | BTN_FIRE;
            end else if (!esc0 && held_gt_long) begin
                o_state.escape_sent    = 1'b1;
                o_state.pulse_bits     = BTN_ESC;
                o_state.pulse_end_time = deadline;
                armed                  = 1'b1;
            end
        end else begin
            o_state.is_dragging = 1'b0;
            if (i_state.was_touched && !drag0 && !esc0 && held_lt_tap) begin
                o_state.pulse_bits     = (org_x >= i_cfg.split_x) ? (BTN_FIRE | BTN_ENTER)
                                                                  : BTN_USE;
                o_state.pulse_end_time = deadline;
                armed                  = 1'b1;
            end
        end

        // freshly armed pulse: now < sat(now + pulse) reduces to these two terms
        if (armed) begin
            show = (i_cfg.pulse_us != '0) && (i_poll.now_us != TIME_MAX);
        end else begin
            show = i_poll.now_us < i_state.pulse_end_time;
        end

        if (show) begin
            mask = mask | o_state.pulse_bits;
        end else begin
            o_state.pulse_bits = '0;
        end

        o_state.previous_mask = mask;
        o_mask    = mask;
        o_changed = mask ^ i_state.previous_mask;
    end
endmodule

// File: sim/tb_touch_gesture_to_buttons.sv
// ============================================================================
// tb_touch_gesture_to_buttons
// Self-checking bench for the touch gesture to button mask block.
// ============================================================================
// A table of hand-built polls covers taps on both halves of the panel, a long
// press, a drag with flipped y below zero, a three-finger poll, time running
// backwards and a pulse deadline clamped at the top of the timestamp range.
// Random gestures follow under several tunings: reset values, all zero, all
// ones and random ones. Every result transfer is checked, against the masks of a fixed
// table row or else against a gesture tracker kept in the bench. Both sides idle in
// bursts, and the receiver holds off once for long enough to back the block up.
// ============================================================================
module tb_touch_gesture_to_buttons;
    import tgb_pkg::*;

    localparam int PHASES      = 6;
    localparam int PHASE_POLLS = 300;
    localparam int CALM_TAIL   = 150;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int DIR_N       = 27;

    localparam logic [CIDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [MASK_W-1:0] BTN_TAP_R  = BTN_FIRE | BTN_ENTER;

    typedef struct packed {
        logic [MASK_W-1:0] btn;
        logic [MASK_W-1:0] chg;
    } t_masks;

    typedef struct packed {
        logic [CNT_W-1:0]   fc;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TIME_W-1:0]  t;
        logic               fixed;
        logic [MASK_W-1:0]  btn;
        logic [MASK_W-1:0]  chg;
    } t_row;

    // fixed rows carry their masks; the rest go through the tracker
    localparam t_row DIR_ROWS [DIR_N] = '{
        '{2'd0,    10'd0,    10'd0, 48'd0,       1'b1, 8'h00,     8'h00},
        '{2'd1,  10'd100,  10'd200, 48'd1000,    1'b1, 8'h00,     8'h00},
        '{2'd0,  10'd100,  10'd200, 48'd100000,  1'b1, BTN_USE,   BTN_USE},
        '{2'd0,    10'd0,    10'd0, 48'd220000,  1'b1, 8'h00,     BTN_USE},
        '{2'd1, 10'd1023,    10'd0, 48'd300000,  1'b1, 8'h00,     8'h00},
        '{2'd0, 10'd1023,    10'd0, 48'd300001,  1'b1, BTN_TAP_R, BTN_TAP_R},
        '{2'd0,    10'd0,    10'd0, 48'd500000,  1'b1, 8'h00,     BTN_TAP_R},
        '{2'd1,  10'd500,    10'd0, 48'd1000000, 1'b1, 8'h00,     8'h00},
        '{2'd1,  10'd500,    10'd0, 48'd1600000, 1'b1, 8'h00,     8'h00},
        '{2'd1,  10'd500,    10'd0, 48'd1600001, 1'b1, BTN_ESC,   BTN_ESC},
        '{2'd0,  10'd500,    10'd0, 48'd1600002, 1'b1, BTN_ESC,   8'h00},
        '{2'd0,    10'd0,    10'd0, 48'd1720001, 1'b1, 8'h00,     BTN_ESC},
        '{2'd2,    10'd0, 10'd1023, 48'd2000000, 1'b0, 8'h00,     8'h00},
        '{2'd2, 10'd1023,    10'd0, 48'd2000100, 1'b0, 8'h00,     8'h00},
        '{2'd3,    10'd0, 10'd1023, 48'd2000200, 1'b0, 8'h00,     8'h00},
        '{2'd1,   10'd26, 10'd1023, 48'd2000300, 1'b0, 8'h00,     8'h00},
        '{2'd0,    10'd0,    10'd0, 48'd2000400, 1'b0, 8'h00,     8'h00},
        '{2'd1,   10'd10,   10'd10, 48'd5000000, 1'b0, 8'h00,     8'h00},
        '{2'd1,   10'd10,   10'd10, 48'd4000000, 1'b0, 8'h00,     8'h00},
        '{2'd0,   10'd10,   10'd10, 48'd3000000, 1'b0, 8'h00,     8'h00},
        '{2'd1,  10'd700,  10'd700, TIME_MAX - 48'd300000, 1'b0, 8'h00, 8'h00},
        '{2'd0,  10'd700,  10'd700, TIME_MAX - 48'd10,     1'b0, 8'h00, 8'h00},
        '{2'd0,    10'd0,    10'd0, TIME_MAX,    1'b0, 8'h00,     8'h00},
        '{2'd1,  10'd233,    10'd0, 48'd9000000, 1'b1, 8'h00,     8'h00},
        '{2'd0,  10'd233,    10'd0, 48'd9400000, 1'b1, 8'h00,     8'h00},
        '{2'd1,  10'd233,    10'd0, 48'd9500000, 1'b1, 8'h00,     8'h00},
        '{2'd0,  10'd233,    10'd0, 48'd9899999, 1'b1, BTN_TAP_R, BTN_TAP_R}
    };

    logic i_clk;
    logic i_rst_n;

    tgb_in_if  poll_if ();
    tgb_out_if res_if ();
    tgb_cfg_if cfg_if ();

    touch_gesture_to_buttons dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (poll_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    // bench copy of the tuning and the gesture state
    t_cfg              tuning;
    logic              pressed;
    logic              dragging;
    logic              esc_done;
    int                org_x;
    int                org_y;
    logic [TIME_W-1:0] press_t;
    logic [TIME_W-1:0] pulse_end;
    logic [MASK_W-1:0] pulse_btn;
    logic [MASK_W-1:0] last_mask;

    t_masks            pending_masks [$];
    t_masks            oldest;
    logic [TIME_W-1:0] t_now;
    int                polls_sent;
    int                results_seen;
    int                errors;
    int                quiet_cycles;
    int                goal;
    bit                calm;
    bit                held_off;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void track_gesture(input t_poll p, output t_masks r);
        int                x, y, dx, dy, dz, thr;
        longint            held;
        logic              touched;
        logic [MASK_W-1:0] m;
        logic [TIME_W:0]   deadline;
        logic [TIME_W-1:0] sat_end;
        x        = int'(p.raw_x);
        y        = (tuning.flip_y_max != '0) ? int'(tuning.flip_y_max) - int'(p.raw_y)
                                             : int'(p.raw_y);
        touched  = (p.finger_count != 2'd0);
        dz       = int'(tuning.dir_margin);
        thr      = int'(tuning.drag_slop);
        m        = '0;
        deadline = {1'b0, p.now_us} + {25'd0, tuning.pulse_us};
        sat_end  = deadline[TIME_W] ? TIME_MAX : deadline[TIME_W-1:0];
        if (touched && !pressed) begin
            org_x    = x;
            org_y    = y;
            press_t  = p.now_us;
            dragging = 1'b0;
            esc_done = 1'b0;
        end
        held = longint'({16'd0, p.now_us}) - longint'({16'd0, press_t});
        if (touched) begin
            dx = x - org_x;
            dy = y - org_y;
            if (!dragging && (((dx < 0) ? -dx : dx) > thr || ((dy < 0) ? -dy : dy) > thr))
                dragging = 1'b1;
            if (dragging) begin
                if (dy < -dz) m |= BTN_UP;
                if (dy > dz)  m |= BTN_DOWN;
                if (dx < -dz) m |= BTN_LEFT;
                if (dx > dz)  m |= BTN_RIGHT;
                if (p.finger_count >= 2'd2) m |= BTN_FIRE;
            end else if (!esc_done && held > longint'({40'd0, tuning.long_press_us})) begin
                esc_done  = 1'b1;
                pulse_btn = BTN_ESC;
                pulse_end = sat_end;
            end
        end else if (pressed) begin
            if (!dragging && !esc_done && held < longint'({40'd0, tuning.tap_max_us})) begin
                pulse_btn = (org_x >= int'(tuning.split_x)) ? BTN_TAP_R : BTN_USE;
                pulse_end = sat_end;
            end
            dragging = 1'b0;
        end
        pressed = touched;
        if (pulse_btn != '0 && p.now_us < pulse_end)
            m |= pulse_btn;
        else
            pulse_btn = '0;
        r.btn     = m;
        r.chg     = m ^ last_mask;
        last_mask = m;
    endfunction

    function automatic logic [COORD_W-1:0] clip10(input int v);
        if (v < 0)
            return '0;
        if (v > 1023)
            return 10'd1023;
        return v[COORD_W-1:0];
    endfunction

    function automatic int jitter(input int j);
        return int'($urandom_range(0, 2 * j)) - j;
    endfunction

    // 10-bit registers take junk in the upper data bits
    function automatic logic [CDAT_W-1:0] coord_word(input logic [COORD_W-1:0] v);
        logic [CDAT_W-1:0] w;
        w             = CDAT_W'($urandom);
        w[COORD_W-1:0] = v;
        return w;
    endfunction

    // steps cluster around the tap, long press and pulse boundaries
    function automatic logic [TIME_W-1:0] time_step();
        longint d;
        case ($urandom_range(0, 7))
            0: d = longint'($urandom_range(0, 2000));
            1: d = longint'($urandom_range(0, 60000));
            2: d = longint'(tuning.tap_max_us) + longint'($urandom_range(0, 4)) - 2;
            3: d = longint'(tuning.long_press_us) + longint'($urandom_range(0, 4)) - 2;
            4: d = longint'(tuning.pulse_us) + longint'($urandom_range(0, 4)) - 2;
            5: d = longint'($urandom_range(0, 1000000));
            6: d = 0;
            default: d = longint'($urandom_range(0, 24'hFFFFFF));
        endcase
        if (d < 0)
            d = 0;
        return d[TIME_W-1:0];
    endfunction

    task automatic send_poll(input logic [CNT_W-1:0] fc, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [TIME_W-1:0] t,
                             input logic fixed, input logic [MASK_W-1:0] btn,
                             input logic [MASK_W-1:0] chg);
        t_poll  p;
        t_masks r;
        p.finger_count = fc;
        p.raw_x        = x;
        p.raw_y        = y;
        p.now_us       = t;
        if (!calm && $urandom_range(0, 4) == 0) begin
            poll_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        poll_if.valid        <= 1'b1;
        poll_if.finger_count <= fc;
        poll_if.raw_x        <= x;
        poll_if.raw_y        <= y;
        poll_if.now_us       <= t;
        @(posedge i_clk);
        while (!poll_if.ready) @(posedge i_clk);
        track_gesture(p, r);
        if (fixed) begin
            r.btn = btn;
            r.chg = chg;
        end
        pending_masks.push_back(r);
        polls_sent++;
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            REG_DIR_MARGIN:     tuning.dir_margin     = val[COORD_W-1:0];
            REG_DRAG_SLOP:      tuning.drag_slop      = val[COORD_W-1:0];
            REG_TAP_MAX_US:     tuning.tap_max_us     = val;
            REG_LONG_PRESS_US:  tuning.long_press_us  = val;
            REG_PULSE_US:       tuning.pulse_us       = val;
            REG_SPLIT_X:        tuning.split_x        = val[COORD_W-1:0];
            REG_FLIP_Y_MAX:     tuning.flip_y_max     = val[COORD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic retune(input int phase);
        logic [COORD_W-1:0] dz, thr, spl, flp;
        logic [DUR_W-1:0]   tap, lng, pls;
        while (pending_masks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        case (phase)
            1: begin
                dz  = '0; thr = '0; spl = '0; flp = '0;
                tap = '0; lng = '0; pls = '0;
            end
            2: begin
                dz  = '1; thr = '1; spl = '1; flp = '1;
                tap = '1; lng = '1; pls = '1;
            end
            PHASES - 1: begin
                dz  = COORD_W'($urandom_range(10, 50));
                thr = COORD_W'($urandom_range(10, 40));
                spl = COORD_W'($urandom_range(0, 1023));
                flp = ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom_range(300, 1023));
                tap = DUR_W'($urandom_range(200000, 500000));
                lng = DUR_W'($urandom_range(400000, 900000));
                pls = DUR_W'($urandom_range(50000, 200000));
            end
            default: begin
                dz  = COORD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                           : $urandom_range(0, 60));
                thr = COORD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                           : $urandom_range(0, 60));
                spl = COORD_W'($urandom_range(0, 1023));
                flp = ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom_range(0, 1023));
                tap = DUR_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                         : $urandom_range(0, 2000000));
                lng = DUR_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                         : $urandom_range(0, 2000000));
                pls = DUR_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                         : $urandom_range(0, 2000000));
            end
        endcase
        write_reg(REG_DIR_MARGIN, coord_word(dz));
        write_reg(REG_DRAG_SLOP, coord_word(thr));
        write_reg(REG_TAP_MAX_US, tap);
        write_reg(REG_LONG_PRESS_US, lng);
        write_reg(REG_PULSE_US, pls);
        write_reg(REG_SPLIT_X, coord_word(spl));
        write_reg(REG_FLIP_Y_MAX, coord_word(flp));
        if (phase == 3)
            write_reg(REG_UNUSED, CDAT_W'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic play_gesture();
        int                 kind, steps, x0, y0, tx, ty, j;
        logic [CNT_W-1:0]   fc;
        logic [63:0]        r;
        kind = int'($urandom_range(0, 9));
        x0   = int'($urandom_range(0, 1023));
        y0   = int'($urandom_range(0, 1023));
        if (kind == 9) begin
            r  = {$urandom, $urandom};
            fc = CNT_W'($urandom_range(0, 3));
            send_poll(fc, clip10(x0), clip10(y0), r[TIME_W-1:0], 1'b0, '0, '0);
            return;
        end
        fc = CNT_W'($urandom_range(1, 3));
        t_now += time_step();
        send_poll(fc, clip10(x0), clip10(y0), t_now, 1'b0, '0, '0);
        if (kind < 3) begin
            // still press: stays inside the move threshold
            j     = int'($urandom_range(0, int'(tuning.drag_slop)));
            steps = int'($urandom_range(0, 3));
            repeat (steps) begin
                t_now += time_step();
                send_poll(fc, clip10(x0 + jitter(j)), clip10(y0 + jitter(j)), t_now,
                          1'b0, '0, '0);
            end
        end else if (kind < 8) begin
            tx    = int'($urandom_range(0, 1023));
            ty    = int'($urandom_range(0, 1023));
            steps = int'($urandom_range(2, 8));
            for (int k = 1; k <= steps; k++) begin
                if (kind > 5)
                    fc = CNT_W'($urandom_range(1, 3));
                t_now += time_step();
                send_poll(fc, clip10(x0 + (tx - x0) * k / steps),
                          clip10(y0 + (ty - y0) * k / steps), t_now, 1'b0, '0, '0);
            end
        end else begin
            // broken press: finger count flickers, point wanders
            steps = int'($urandom_range(2, 6));
            repeat (steps) begin
                fc = CNT_W'($urandom_range(0, 3));
                t_now += time_step();
                send_poll(fc, clip10(x0 + jitter(64)), clip10(y0 + jitter(64)), t_now,
                          1'b0, '0, '0);
            end
        end
        t_now += time_step();
        send_poll(2'd0, clip10(int'($urandom_range(0, 1023))),
                  clip10(int'($urandom_range(0, 1023))), t_now, 1'b0, '0, '0);
        repeat ($urandom_range(0, 2)) begin
            t_now += time_step();
            send_poll(2'd0, clip10(int'($urandom_range(0, 1023))),
                      clip10(int'($urandom_range(0, 1023))), t_now, 1'b0, '0, '0);
        end
    endtask

    // result side: random ready bursts, one long hold-off
    initial begin
        res_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && results_seen >= 80) begin
                held_off = 1'b1;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (calm || $urandom_range(0, 2) != 0) begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (pending_masks.size() == 0) begin
                errors++;
                $error("button_mask: expected none, got %02h", res_if.button_mask);
            end else begin
                oldest = pending_masks.pop_front();
                if (res_if.button_mask !== oldest.btn) begin
                    errors++;
                    $error("button_mask: expected %02h, got %02h", oldest.btn,
                           res_if.button_mask);
                end
                if (res_if.changed_mask !== oldest.chg) begin
                    errors++;
                    $error("changed_mask: expected %02h, got %02h", oldest.chg,
                           res_if.changed_mask);
                end
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (poll_if.valid && poll_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        poll_if.valid        <= 1'b0;
        poll_if.finger_count <= '0;
        poll_if.raw_x        <= '0;
        poll_if.raw_y        <= '0;
        poll_if.now_us       <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= '0;
        cfg_if.data          <= '0;
        tuning = '{RST_DIR_MARGIN, RST_DRAG_SLOP, RST_TAP_MAX_US, RST_LONG_PRESS_US,
                   RST_PULSE_US, RST_SPLIT_X, RST_FLIP_Y_MAX};
        pressed      = 1'b0;
        dragging     = 1'b0;
        esc_done     = 1'b0;
        org_x        = 0;
        org_y        = 0;
        press_t      = '0;
        pulse_end    = '0;
        pulse_btn    = '0;
        last_mask    = '0;
        polls_sent   = 0;
        results_seen = 0;
        errors       = 0;
        calm         = 1'b0;
        held_off     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++)
            send_poll(DIR_ROWS[i].fc, DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].t,
                      DIR_ROWS[i].fixed, DIR_ROWS[i].btn, DIR_ROWS[i].chg);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                poll_if.valid <= 1'b0;
                retune(phase);
            end
            t_now = {16'd0, $urandom};
            goal  = polls_sent + PHASE_POLLS;
            while (polls_sent < goal) begin
                if (phase == PHASES - 1 && goal - polls_sent < CALM_TAIL)
                    calm = 1'b1;
                play_gesture();
            end
        end
        poll_if.valid <= 1'b0;

        while (pending_masks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
